### rtl/core/otl_pkg.sv
// package for the one-shot timer list
// holds field widths, item structs, op and state codes; no dependencies
`timescale 1ns / 1ps

package otl_pkg;

  localparam int SLOTS_DEF   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int ID_W        = 16;
  localparam int TIME_W      = 32;

  localparam logic [ID_W-1:0] ID_NONE  = '0;
  localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);

  // result kinds
  localparam logic KIND_SET  = 1'b0;
  localparam logic KIND_FIRE = 1'b1;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [1:0]        op;
    logic [TIME_W-1:0] delay_ticks;
    logic [ID_W-1:0]   cancel_id;
    logic [TIME_W-1:0] elapsed_ticks;
  } in_item_t;

  typedef struct packed {
    logic            kind;
    logic [ID_W-1:0] timer_id;
    logic            last;
  } out_item_t;

  // one list entry as held in a cell
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] remaining;
  } entry_t;

  // per-cycle control shared by all cells
  typedef struct packed {
    logic shift;
    logic wr;
  } cell_ctl_t;

endpackage

### rtl/core/one_shot_timer_list.sv
// top level of the one-shot timer list: control sequencer and the chain of entry cells
// depends on otl_pkg and otl_cell
`timescale 1ns / 1ps

// One-shot timer list. Items arrive on in_valid/in_stall/in_item and results leave
// on out_valid/out_stall/out_item; a transfer happens when valid is high and stall low.
// Entries live in a chain of SLOTS cells in insertion order, oldest at cell 0.
// set: the entry is written at the tail in the accept cycle; the id result (0 when
//   the list is full) is held, then offered from the output register once it is free.
// cancel and tick: the chain rotates one cell per cycle past the head while no stalled
//   output holds the pass; each head entry is checked by the single head compare/subtract,
//   then rewritten at the tail or dropped.
// Fired ids leave in list order; each is held until the next one (or the pass end)
//   shows whether it is the last. A stalled receiver holds the pass at a firing head entry
//   while the output register and the held result are both full.
// Only one item is in work at a time: in_stall is high outside the idle state.
// Reset (rst_n low, synchronous) empties the list and sets the next id to 1;
// cell contents are not cleared, entries beyond the count are never read.
// cancel, undefined ops and ticks that fire nothing give no result.
module one_shot_timer_list
  import otl_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int FC_W  = $clog2(MAX_RESULTS + 1);

  // control state
  state_e            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  iter_r, iter_nxt;
  logic [ID_W-1:0]   next_id_r, next_id_nxt;
  logic              found_r, found_nxt;
  logic [FC_W-1:0]   fire_cnt_r, fire_cnt_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload state
  logic [1:0]        op_r, op_nxt;
  logic [ID_W-1:0]   cid_r, cid_nxt;
  logic [TIME_W-1:0] elapsed_r, elapsed_nxt;
  logic              pend_kind_r, pend_kind_nxt;
  logic [ID_W-1:0]   pend_id_r, pend_id_nxt;
  out_item_t         out_item_r, out_item_nxt;

  // cell chain
  entry_t            cell_q [SLOTS];
  cell_ctl_t         ctl;
  logic [CNT_W-1:0]  wr_idx;
  entry_t            wr_data;

  // pass datapath
  entry_t            head;
  logic              le;
  logic [TIME_W-1:0] new_rem;
  logic              report;
  logic              match;
  logic              keep;
  logic              out_free;
  logic              accept;
  logic [ID_W-1:0]   id_inc;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign head     = cell_q[0];

  // head entry check
  always_comb begin
    le      = (head.remaining <= elapsed_r);
    new_rem = le ? '0 : (head.remaining - elapsed_r);
    report  = (op_r == OP_TICK) && le && (fire_cnt_r < FC_W'(MAX_RESULTS));
    match   = (op_r == OP_CANCEL) && !found_r && (head.id == cid_r);
    keep    = !(report || match);
    id_inc  = next_id_r + ID_W'(1);
  end

  // sequencer: next state, cell control and result staging
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    iter_nxt       = iter_r;
    next_id_nxt    = next_id_r;
    found_nxt      = found_r;
    fire_cnt_nxt   = fire_cnt_r;
    pend_valid_nxt = pend_valid_r;
    pend_kind_nxt  = pend_kind_r;
    pend_id_nxt    = pend_id_r;
    op_nxt         = op_r;
    cid_nxt        = cid_r;
    elapsed_nxt    = elapsed_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_item_nxt   = out_item_r;
    ctl            = '0;
    wr_idx         = count_r;
    wr_data        = head;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt      = in_item.op;
          cid_nxt     = in_item.cancel_id;
          elapsed_nxt = in_item.elapsed_ticks;
          case (in_item.op)
            OP_SET: begin
              pend_valid_nxt = 1'b1;
              pend_kind_nxt  = KIND_SET;
              if (count_r < CNT_W'(SLOTS)) begin
                ctl.wr          = 1'b1;
                wr_idx          = count_r;
                wr_data.id        = next_id_r;
                wr_data.remaining = in_item.delay_ticks;
                count_nxt       = count_r + CNT_W'(1);
                next_id_nxt     = (id_inc == ID_NONE) ? ID_FIRST : id_inc;
                pend_id_nxt     = next_id_r;
              end else begin
                pend_id_nxt     = ID_NONE;
              end
              state_nxt = ST_FLUSH;
            end
            OP_CANCEL, OP_TICK: begin
              iter_nxt     = count_r;
              found_nxt    = 1'b0;
              fire_cnt_nxt = '0;
              state_nxt    = ST_PASS;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_PASS: begin
        if (iter_r == '0) begin
          state_nxt = ST_FLUSH;
        end else if (!(report && pend_valid_r && !out_free)) begin
          // rotate: head leaves, kept entries go back in at the tail
          ctl.shift = 1'b1;
          iter_nxt  = iter_r - CNT_W'(1);
          if (keep) begin
            ctl.wr            = 1'b1;
            wr_idx            = count_r - CNT_W'(1);
            wr_data.id        = head.id;
            wr_data.remaining = (op_r == OP_TICK) ? new_rem : head.remaining;
          end else begin
            count_nxt = count_r - CNT_W'(1);
          end
          if (match) begin
            found_nxt = 1'b1;
          end
          if (report) begin
            if (pend_valid_r) begin
              out_valid_nxt         = 1'b1;
              out_item_nxt.kind     = pend_kind_r;
              out_item_nxt.timer_id = pend_id_r;
              out_item_nxt.last     = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_kind_nxt  = KIND_FIRE;
            pend_id_nxt    = head.id;
            fire_cnt_nxt   = fire_cnt_r + FC_W'(1);
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_item_nxt.kind     = pend_kind_r;
          out_item_nxt.timer_id = pend_id_r;
          out_item_nxt.last     = 1'b1;
          pend_valid_nxt        = 1'b0;
          state_nxt             = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      iter_r       <= '0;
      next_id_r    <= ID_FIRST;
      found_r      <= 1'b0;
      fire_cnt_r   <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      iter_r       <= iter_nxt;
      next_id_r    <= next_id_nxt;
      found_r      <= found_nxt;
      fire_cnt_r   <= fire_cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    cid_r       <= cid_nxt;
    elapsed_r   <= elapsed_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_id_r   <= pend_id_nxt;
    out_item_r  <= out_item_nxt;
  end

  // chain of cells, each fed by its right neighbor; the tail cell is fed by itself
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    entry_t nbr;
    if (g == SLOTS - 1) begin : g_tail
      assign nbr = cell_q[g];
    end else begin : g_body
      assign nbr = cell_q[g+1];
    end
    otl_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .nbr     (nbr),
      .q       (cell_q[g])
    );
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### rtl/core/otl_cell.sv
// one storage cell of the timer chain: holds one entry
// loads from its right neighbor on shift or takes a write aimed at its slot; uses otl_pkg
`timescale 1ns / 1ps

module otl_cell
  import otl_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [CNT_W-1:0] wr_idx,
  input  entry_t           wr_data,
  input  entry_t           nbr,
  output entry_t           q
);

  entry_t q_r;
  entry_t q_nxt;
  logic   sel;

  // write wins over the shift from the neighbor
  always_comb begin
    sel = ctl.wr && (wr_idx == CNT_W'(IDX));
    if (sel) begin
      q_nxt = wr_data;
    end else if (ctl.shift) begin
      q_nxt = nbr;
    end else begin
      q_nxt = q_r;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule
